FILE: hw/rtl/associated_legendre_eval_top_assert.svh
// assertion macros shared by the legendre evaluator checkers
`ifndef ASSOCIATED_LEGENDRE_EVAL_TOP_ASSERT_SVH
`define ASSOCIATED_LEGENDRE_EVAL_TOP_ASSERT_SVH
// same-cycle implication
`define ALE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ALE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hw/rtl/ale_pkg.sv
// shared constants, types and helpers of the legendre evaluator
`default_nettype none
package ale_pkg;

    localparam int MAX_DEGREE    = 8;
    localparam int X_FRAC_BITS   = 30;
    localparam int OUT_FRAC_BITS = 32;

    localparam logic [63:0] ONE_F   = 64'(1) << OUT_FRAC_BITS;
    localparam logic [63:0] ONE_X64 = 64'(1) << X_FRAC_BITS;
    localparam logic signed [31:0] ONE_X32 = 32'sd1 <<< X_FRAC_BITS;
    localparam logic [63:0] ONE_XX  = 64'(1) << (2 * X_FRAC_BITS);

    localparam int ROOT_SHL = (OUT_FRAC_BITS >= X_FRAC_BITS) ?
                              2 * (OUT_FRAC_BITS - X_FRAC_BITS) : 0;
    localparam int ROOT_SHR = (OUT_FRAC_BITS >= X_FRAC_BITS) ?
                              0 : 2 * (X_FRAC_BITS - OUT_FRAC_BITS);

    localparam logic CMD_VALUE = 1'b0;
    localparam logic CMD_DERIV = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_X_RANGE   = 3'd1,
        STAT_ORDER     = 3'd2,
        STAT_SINGULAR  = 3'd3,
        STAT_SAT       = 3'd4
    } status_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic        [63:0] c;
    } md_req_t;

    typedef struct packed {
        logic               done;
        logic               ovf;
        logic signed [63:0] q;
    } md_res_t;

    typedef struct packed {
        logic               ovf;
        logic signed [63:0] d;
    } sat_t;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_ROUND,
        MD_CHK,
        MD_DIV,
        MD_FIN
    } md_state_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ_MUL,
        S_ROOT,
        S_LEG_START,
        S_SECT,
        S_SECT_R,
        S_FIRST_R,
        S_REC,
        S_REC_T1R,
        S_REC_T2R,
        S_REC_DR,
        S_POS_DONE,
        S_FACT,
        S_FACT_R,
        S_NEG_R,
        S_LEG_RET,
        S_NUM_R,
        S_B_R,
        S_DDIV,
        S_DDIV_R,
        S_MD_WAIT,
        S_OUT
    } ale_state_t;

    // saturating a - b
    function automatic sat_t sat_sub(input logic signed [63:0] a,
                                     input logic signed [63:0] b);
        logic signed [64:0] diff;
        sat_t res;
        diff = {a[63], a} - {b[63], b};
        res.ovf = diff[64] != diff[63];
        if (res.ovf)
        begin
            res.d = diff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            res.d = diff[63:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/associated_legendre_eval_top.sv
// associated legendre function evaluator: top level sequencer
// steps: setup and square root, then any passes through the shared round(a*b/c)
//   unit that the request needs
// requests: one at a time; the next request is taken once the result is
//   handed to the output register
// reset: asynchronous active low, clears the sequencer and the output valid
`default_nettype none
module associated_legendre_eval_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [4:0]  degree,
    input  wire logic [4:0]  order,
    input  wire logic [31:0] x_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      value,
    output logic [2:0]       status
);

    ale_pkg::ale_state_t state_reg, state_next, ret_reg, ret_next;
    ale_pkg::status_t    stat_reg, stat_next, status_out_reg, status_out_next;
    ale_pkg::md_req_t    md_req;
    ale_pkg::md_res_t    md_res;

    logic               cmd_reg, cmd_next;
    logic [4:0]         l_reg, l_next, pl_reg, pl_next, mm_reg, mm_next;
    logic [4:0]         ord_reg, ord_next;
    logic               mneg_reg, mneg_next, pass_reg, pass_next;
    logic [5:0]         k_reg, k_next, b_reg, b_next;
    logic [31:0]        xs_reg, xs_next;
    logic [63:0]        w_reg, w_next, s_reg, s_next, r_reg, r_next, d_reg, d_next;
    logic [127:0]       v_reg, v_next, rsq_reg, rsq_next;
    logic signed [63:0] cur_reg, cur_next, prev_reg, prev_next, tmp_reg, tmp_next;
    logic signed [63:0] num_reg, num_next, res_reg, res_next, mdq_reg, mdq_next;
    logic               sgn_reg, sgn_next, ovf_reg, ovf_next;
    logic               out_valid_reg, out_valid_next;
    logic [63:0]        value_out_reg, value_out_next;

    logic [4:0]         lmap;
    logic signed [5:0]  ord6, negl6;
    logic [31:0]        mx;
    logic [63:0]        mx2, wx;
    logic [63:0]        t_root;
    logic [127:0]       tsq;
    logic [63:0]        xs64;
    logic [6:0]         k2m1, mm2p1;
    logic [5:0]         kmax;
    logic [68:0]        fprod;
    logic signed [5:0]  lpo;
    ale_pkg::sat_t      sub_rec, sub_der;
    logic               in_take, out_free;

    ale_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .res   (md_res)
    );

    assign in_stall  = state_reg != ale_pkg::S_IDLE;
    assign out_valid = out_valid_reg;
    assign value     = value_out_reg;
    assign status    = status_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ale_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg        <= ret_next;
        stat_reg       <= stat_next;
        status_out_reg <= status_out_next;
        cmd_reg        <= cmd_next;
        l_reg          <= l_next;
        pl_reg         <= pl_next;
        mm_reg         <= mm_next;
        ord_reg        <= ord_next;
        mneg_reg       <= mneg_next;
        pass_reg       <= pass_next;
        k_reg          <= k_next;
        b_reg          <= b_next;
        xs_reg         <= xs_next;
        w_reg          <= w_next;
        s_reg          <= s_next;
        r_reg          <= r_next;
        d_reg          <= d_next;
        v_reg          <= v_next;
        rsq_reg        <= rsq_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        tmp_reg        <= tmp_next;
        num_reg        <= num_next;
        res_reg        <= res_next;
        mdq_reg        <= mdq_next;
        sgn_reg        <= sgn_next;
        ovf_reg        <= ovf_next;
        value_out_reg  <= value_out_next;
    end

    always_comb
    begin
        in_take  = in_valid && state_reg == ale_pkg::S_IDLE;
        out_free = !out_valid_reg || !out_stall;
        lmap     = degree[4] ? ~degree : degree;
        ord6     = $signed({order[4], order});
        negl6    = $signed(6'd0 - {1'b0, lmap});
        mx       = xs_reg[31] ? 32'd0 - xs_reg : xs_reg;
        mx2      = 64'(mx) * 64'(mx);
        wx       = ale_pkg::ONE_XX - mx2;
        t_root   = r_reg | (64'(1) << b_reg);
        tsq      = rsq_reg + (128'(r_reg) << (7'(b_reg) + 7'd1))
                   + (128'(1) << {b_reg, 1'b0});
        xs64     = {{32{xs_reg[31]}}, xs_reg};
        k2m1     = {k_reg, 1'b0} - 7'd1;
        mm2p1    = {1'b0, mm_reg, 1'b0} + 7'd1;
        kmax     = {1'b0, pl_reg} + {1'b0, mm_reg};
        fprod    = 69'(d_reg) * 69'(k_reg);
        lpo      = $signed({1'b0, l_reg}) + $signed({ord_reg[4], ord_reg});
        sub_rec  = ale_pkg::sat_sub(tmp_reg, mdq_reg);
        sub_der  = ale_pkg::sat_sub(num_reg, mdq_reg);

        state_next      = state_reg;
        ret_next        = ret_reg;
        stat_next       = stat_reg;
        status_out_next = status_out_reg;
        cmd_next        = cmd_reg;
        l_next          = l_reg;
        pl_next         = pl_reg;
        mm_next         = mm_reg;
        ord_next        = ord_reg;
        mneg_next       = mneg_reg;
        pass_next       = pass_reg;
        k_next          = k_reg;
        b_next          = b_reg;
        xs_next         = xs_reg;
        w_next          = w_reg;
        s_next          = s_reg;
        r_next          = r_reg;
        d_next          = d_reg;
        v_next          = v_reg;
        rsq_next        = rsq_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        tmp_next        = tmp_reg;
        num_next        = num_reg;
        res_next        = res_reg;
        mdq_next        = mdq_reg;
        sgn_next        = sgn_reg;
        ovf_next        = ovf_reg;
        value_out_next  = value_out_reg;
        out_valid_next  = out_valid_reg && out_stall;
        md_req          = '0;

        unique case (state_reg)
            ale_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    cmd_next  = command;
                    l_next    = lmap;
                    ord_next  = order;
                    xs_next   = x_value;
                    ovf_next  = 1'b0;
                    res_next  = '0;
                    stat_next = ale_pkg::STAT_OK;
                    state_next = ale_pkg::S_OUT;
                    if ($signed(x_value) > ale_pkg::ONE_X32
                        || $signed(x_value) < -ale_pkg::ONE_X32)
                    begin
                        stat_next = ale_pkg::STAT_X_RANGE;
                    end
                    else if (ord6 < negl6)
                    begin
                        stat_next = ale_pkg::STAT_ORDER;
                    end
                    else if (lmap > 5'(ale_pkg::MAX_DEGREE))
                    begin
                        stat_next = ale_pkg::STAT_SAT;
                    end
                    else if (command == ale_pkg::CMD_DERIV
                             && ($signed(x_value) == ale_pkg::ONE_X32
                                 || $signed(x_value) == -ale_pkg::ONE_X32))
                    begin
                        stat_next = ale_pkg::STAT_SINGULAR;
                    end
                    else
                    begin
                        state_next = ale_pkg::S_SQ_MUL;
                    end
                end
            end
            ale_pkg::S_SQ_MUL:
            begin
                w_next     = wx;
                v_next     = (128'(wx) << ale_pkg::ROOT_SHL) >> ale_pkg::ROOT_SHR;
                r_next     = '0;
                rsq_next   = '0;
                b_next     = 6'(ale_pkg::OUT_FRAC_BITS);
                state_next = ale_pkg::S_ROOT;
            end
            ale_pkg::S_ROOT:
            begin
                // one result bit per cycle, square tracked incrementally
                if (tsq <= v_reg)
                begin
                    r_next   = t_root;
                    rsq_next = tsq;
                end
                b_next = b_reg - 6'd1;
                if (b_reg == 6'd0)
                begin
                    s_next     = (tsq <= v_reg) ? t_root : r_reg;
                    pass_next  = 1'b0;
                    pl_next    = l_reg;
                    state_next = ale_pkg::S_LEG_START;
                end
            end
            ale_pkg::S_LEG_START:
            begin
                mm_next   = ord_reg[4] ? 5'd0 - ord_reg : ord_reg;
                mneg_next = ord_reg[4];
                if ($signed({ord_reg[4], ord_reg}) > $signed({1'b0, pl_reg}))
                begin
                    cur_next   = '0;
                    state_next = ale_pkg::S_LEG_RET;
                end
                else
                begin
                    cur_next   = ale_pkg::ONE_F;
                    k_next     = 6'd1;
                    state_next = ale_pkg::S_SECT;
                end
            end
            ale_pkg::S_SECT:
            begin
                state_next = ale_pkg::S_MD_WAIT;
                md_req.start = 1'b1;
                md_req.a     = cur_reg;
                if (k_reg <= {1'b0, mm_reg})
                begin
                    md_req.b = 64'(0) - 64'(s_reg * 64'(k2m1));
                    md_req.c = ale_pkg::ONE_F;
                    ret_next = ale_pkg::S_SECT_R;
                end
                else if (pl_reg == mm_reg)
                begin
                    md_req.start = 1'b0;
                    state_next   = ale_pkg::S_POS_DONE;
                end
                else
                begin
                    prev_next = cur_reg;
                    md_req.b  = 64'(xs64 * 64'(mm2p1));
                    md_req.c  = ale_pkg::ONE_X64;
                    ret_next  = ale_pkg::S_FIRST_R;
                end
            end
            ale_pkg::S_SECT_R:
            begin
                cur_next   = mdq_reg;
                k_next     = k_reg + 6'd1;
                state_next = ale_pkg::S_SECT;
            end
            ale_pkg::S_FIRST_R:
            begin
                cur_next   = mdq_reg;
                k_next     = {1'b0, mm_reg} + 6'd2;
                state_next = ale_pkg::S_REC;
            end
            ale_pkg::S_REC:
            begin
                if (k_reg <= {1'b0, pl_reg})
                begin
                    md_req.start = 1'b1;
                    md_req.a     = cur_reg;
                    md_req.b     = 64'(xs64 * 64'(k2m1));
                    md_req.c     = ale_pkg::ONE_X64;
                    ret_next     = ale_pkg::S_REC_T1R;
                    state_next   = ale_pkg::S_MD_WAIT;
                end
                else
                begin
                    state_next = ale_pkg::S_POS_DONE;
                end
            end
            ale_pkg::S_REC_T1R:
            begin
                tmp_next     = mdq_reg;
                md_req.start = 1'b1;
                md_req.a     = prev_reg;
                md_req.b     = 64'(k_reg) - 64'd1 + 64'(mm_reg);
                md_req.c     = 64'd1;
                ret_next     = ale_pkg::S_REC_T2R;
                state_next   = ale_pkg::S_MD_WAIT;
            end
            ale_pkg::S_REC_T2R:
            begin
                ovf_next     = ovf_reg | sub_rec.ovf;
                md_req.start = 1'b1;
                md_req.a     = sub_rec.d;
                md_req.b     = 64'sd1;
                md_req.c     = 64'(k_reg) - 64'(mm_reg);
                ret_next     = ale_pkg::S_REC_DR;
                state_next   = ale_pkg::S_MD_WAIT;
            end
            ale_pkg::S_REC_DR:
            begin
                prev_next  = cur_reg;
                cur_next   = mdq_reg;
                k_next     = k_reg + 6'd1;
                state_next = ale_pkg::S_REC;
            end
            ale_pkg::S_POS_DONE:
            begin
                if (mneg_reg)
                begin
                    d_next     = 64'd1;
                    sgn_next   = mm_reg[0];
                    k_next     = {1'b0, pl_reg} - {1'b0, mm_reg} + 6'd1;
                    state_next = ale_pkg::S_FACT;
                end
                else
                begin
                    state_next = ale_pkg::S_LEG_RET;
                end
            end
            ale_pkg::S_FACT:
            begin
                // factorial ratio, one factor per cycle unless a 64-bit run is being divided out
                md_req.a = cur_reg;
                md_req.b = sgn_reg ? -64'sd1 : 64'sd1;
                md_req.c = d_reg;
                if (k_reg <= kmax)
                begin
                    if (fprod[68:64] != 5'd0)
                    begin
                        md_req.start = 1'b1;
                        ret_next     = ale_pkg::S_FACT_R;
                        state_next   = ale_pkg::S_MD_WAIT;
                    end
                    else
                    begin
                        d_next = fprod[63:0];
                        k_next = k_reg + 6'd1;
                    end
                end
                else
                begin
                    md_req.start = 1'b1;
                    ret_next     = ale_pkg::S_NEG_R;
                    state_next   = ale_pkg::S_MD_WAIT;
                end
            end
            ale_pkg::S_FACT_R:
            begin
                cur_next   = mdq_reg;
                sgn_next   = 1'b0;
                d_next     = 64'd1;
                state_next = ale_pkg::S_FACT;
            end
            ale_pkg::S_NEG_R:
            begin
                cur_next   = mdq_reg;
                state_next = ale_pkg::S_LEG_RET;
            end
            ale_pkg::S_LEG_RET:
            begin
                if (cmd_reg == ale_pkg::CMD_VALUE)
                begin
                    res_next   = cur_reg;
                    state_next = ale_pkg::S_OUT;
                end
                else
                begin
                    md_req.start = 1'b1;
                    md_req.a     = cur_reg;
                    md_req.c     = pass_reg ? 64'd1 : ale_pkg::ONE_X64;
                    md_req.b     = pass_reg ? 64'($signed(lpo))
                                            : 64'(xs64 * 64'(l_reg));
                    ret_next     = pass_reg ? ale_pkg::S_B_R : ale_pkg::S_NUM_R;
                    state_next   = ale_pkg::S_MD_WAIT;
                end
            end
            ale_pkg::S_NUM_R:
            begin
                num_next = mdq_reg;
                if (lpo != 6'sd0)
                begin
                    pass_next  = 1'b1;
                    pl_next    = (l_reg == 5'd0) ? 5'd0 : l_reg - 5'd1;
                    state_next = ale_pkg::S_LEG_START;
                end
                else
                begin
                    state_next = ale_pkg::S_DDIV;
                end
            end
            ale_pkg::S_B_R:
            begin
                num_next   = sub_der.d;
                ovf_next   = ovf_reg | sub_der.ovf;
                state_next = ale_pkg::S_DDIV;
            end
            ale_pkg::S_DDIV:
            begin
                md_req.start = 1'b1;
                md_req.a     = num_reg;
                md_req.b     = 64'(0) - ale_pkg::ONE_XX;
                md_req.c     = w_reg;
                ret_next     = ale_pkg::S_DDIV_R;
                state_next   = ale_pkg::S_MD_WAIT;
            end
            ale_pkg::S_DDIV_R:
            begin
                res_next   = mdq_reg;
                state_next = ale_pkg::S_OUT;
            end
            ale_pkg::S_MD_WAIT:
            begin
                if (md_res.done)
                begin
                    mdq_next   = md_res.q;
                    ovf_next   = ovf_reg | md_res.ovf;
                    state_next = ret_reg;
                end
            end
            ale_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    value_out_next  = res_reg;
                    status_out_next = ovf_reg ? ale_pkg::STAT_SAT : stat_reg;
                    out_valid_next  = 1'b1;
                    state_next      = ale_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ale_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/ale_muldiv.sv
// shared round(a*b/c) unit: four partial products, then restoring division
`default_nettype none
module ale_muldiv (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ale_pkg::md_req_t req,
    output ale_pkg::md_res_t      res
);

    ale_pkg::md_state_t state_reg, state_next;
    logic         neg_reg, neg_next;
    logic [63:0]  ma_reg, ma_next, mb_reg, mb_next, c_reg, c_next;
    logic [127:0] acc_reg, acc_next;
    logic [1:0]   ph_reg, ph_next;
    logic [64:0]  rem_reg, rem_next;
    logic [63:0]  lo_reg, lo_next, q_reg, q_next;
    logic [5:0]   cnt_reg, cnt_next;
    logic         done_reg, done_next, ovf_reg, ovf_next;
    logic signed [63:0] qout_reg, qout_next;

    logic [31:0]  ai, bi;
    logic [63:0]  pp;
    logic [6:0]   pp_sh;
    logic [64:0]  rem2;
    logic         ge;

    assign res = '{done: done_reg, ovf: ovf_reg, q: qout_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ale_pkg::MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= neg_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        c_reg    <= c_next;
        acc_reg  <= acc_next;
        ph_reg   <= ph_next;
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        ovf_reg  <= ovf_next;
        qout_reg <= qout_next;
    end

    always_comb
    begin
        ai    = ph_reg[1] ? ma_reg[63:32] : ma_reg[31:0];
        bi    = ph_reg[0] ? mb_reg[63:32] : mb_reg[31:0];
        pp    = ai * bi;
        pp_sh = ({6'd0, ph_reg[0]} + {6'd0, ph_reg[1]}) << 5;
        rem2  = {rem_reg[63:0], lo_reg[63]};
        ge    = rem2 >= {1'b0, c_reg};

        state_next = state_reg;
        neg_next   = neg_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        c_next     = c_reg;
        acc_next   = acc_reg;
        ph_next    = ph_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        ovf_next   = ovf_reg;
        qout_next  = qout_reg;

        unique case (state_reg)
            ale_pkg::MD_IDLE:
            begin
                if (req.start)
                begin
                    neg_next = req.a[63] != req.b[63];
                    ma_next  = req.a[63] ? 64'(0) - req.a : req.a;
                    mb_next  = req.b[63] ? 64'(0) - req.b : req.b;
                    c_next   = req.c;
                    acc_next = '0;
                    ph_next  = 2'd0;
                    if (req.c == 64'd0)
                    begin
                        ovf_next   = 1'b1;
                        qout_next  = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = ale_pkg::MD_MUL;
                    end
                end
            end
            ale_pkg::MD_MUL:
            begin
                acc_next = acc_reg + (128'(pp) << pp_sh);
                ph_next  = ph_reg + 2'd1;
                if (ph_reg == 2'd3)
                begin
                    state_next = ale_pkg::MD_ROUND;
                end
            end
            ale_pkg::MD_ROUND:
            begin
                acc_next   = acc_reg + 128'(c_reg >> 1);
                state_next = ale_pkg::MD_CHK;
            end
            ale_pkg::MD_CHK:
            begin
                if (acc_reg[127:64] >= c_reg)
                begin
                    ovf_next   = 1'b1;
                    qout_next  = neg_reg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    done_next  = 1'b1;
                    state_next = ale_pkg::MD_IDLE;
                end
                else
                begin
                    rem_next   = {1'b0, acc_reg[127:64]};
                    lo_next    = acc_reg[63:0];
                    q_next     = '0;
                    cnt_next   = 6'd63;
                    state_next = ale_pkg::MD_DIV;
                end
            end
            ale_pkg::MD_DIV:
            begin
                rem_next = ge ? rem2 - {1'b0, c_reg} : rem2;
                q_next   = {q_reg[62:0], ge};
                lo_next  = lo_reg << 1;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    state_next = ale_pkg::MD_FIN;
                end
            end
            ale_pkg::MD_FIN:
            begin
                // clamp magnitude into the signed range
                ovf_next = 1'b0;
                if (!neg_reg)
                begin
                    if (q_reg[63])
                    begin
                        ovf_next  = 1'b1;
                        qout_next = {1'b0, {63{1'b1}}};
                    end
                    else
                    begin
                        qout_next = q_reg;
                    end
                end
                else if (q_reg[63] && q_reg[62:0] != 63'd0)
                begin
                    ovf_next  = 1'b1;
                    qout_next = {1'b1, 63'd0};
                end
                else
                begin
                    qout_next = 64'(0) - q_reg;
                end
                done_next  = 1'b1;
                state_next = ale_pkg::MD_IDLE;
            end
            default:
            begin
                state_next = ale_pkg::MD_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/ale_checker.sv
// port-level checker for the legendre evaluator, bound to the top level
`default_nettype none
`include "associated_legendre_eval_top_assert.svh"
module ale_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        command,
    input wire logic [4:0]  degree,
    input wire logic [4:0]  order,
    input wire logic [31:0] x_value,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [63:0] value,
    input wire logic [2:0]  status
);

    logic in_fire;
    logic err_code;

    assign in_fire  = in_valid && !in_stall;
    assign err_code = status == ale_pkg::STAT_X_RANGE || status == ale_pkg::STAT_ORDER
                      || status == ale_pkg::STAT_SINGULAR;

    `ALE_ASSERT_NXT(a_busy_after_request, in_fire, in_stall, "not busy after request")
    `ALE_ASSERT_IMP(a_err_zero, out_valid && err_code, value == 64'd0, "error with value")
    `ALE_ASSERT_IMP(a_status_code, out_valid, status <= ale_pkg::STAT_SAT, "bad status")
    `ALE_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(value) && $stable(status), "result changed")

endmodule

bind associated_legendre_eval_top ale_checker u_ale_checker (.*);
`default_nettype wire
